// File: rtl/hysteresis_alarm_controller_top_macros.svh
// Assertion macros for the hysteresis alarm controller.
// Used by the top level; expects clk and rst_n in scope.
`ifndef HYSTERESIS_ALARM_CONTROLLER_TOP_MACROS_SVH
`define HYSTERESIS_ALARM_CONTROLLER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define HAC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define HAC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define HAC_ASSERT_SAME(label, ante, cons)
`define HAC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/hac_pkg.sv
// Package for the hysteresis alarm controller: codes, constants and shared types.
// No dependencies.
package hac_pkg;

  localparam int unsigned VAL_W   = 16;
  localparam int unsigned SPD_W   = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [VAL_W-1:0] DEFAULT_THRESHOLD_MV = 16'd2000;

  localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_SPEED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_SPEED  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL    = 3'd3;

  localparam logic [VAL_W-1:0]        RST_HYSTERESIS  = 16'd100;
  localparam logic signed [SPD_W-1:0] RST_ALARM_SPEED = 8'sd80;
  localparam logic signed [SPD_W-1:0] RST_STOP_SPEED  = 8'sd0;
  localparam logic [VAL_W-1:0]        RST_INTERVAL    = 16'd10;

  typedef enum logic [2:0] {
    OP_SENSOR     = 3'd0,
    OP_SET_AUTO   = 3'd1,
    OP_MANUAL_ON  = 3'd2,
    OP_MANUAL_OFF = 3'd3,
    OP_THRESHOLD  = 3'd4,
    OP_TICK       = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    MODE_AUTO_MONITOR = 2'd0,
    MODE_AUTO_ALARM   = 2'd1,
    MODE_MANUAL_ON    = 2'd2,
    MODE_MANUAL_OFF   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [VAL_W-1:0]        hysteresis_mv;
    logic signed [SPD_W-1:0] alarm_motor_speed;
    logic signed [SPD_W-1:0] stop_motor_speed;
    logic [VAL_W-1:0]        warning_interval;
  } cfg_t;

  typedef struct packed {
    logic [1:0]              mode;
    logic                    alarm_active;
    logic                    manual_mode;
    logic                    indicator_on;
    logic signed [SPD_W-1:0] motor_drive;
    logic                    warning_pulse;
  } result_t;

endpackage

// File: rtl/hac_cfg_regs.sv
// Configuration register file of the hysteresis alarm controller.
// Depends on hac_pkg.
module hac_cfg_regs
  import hac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_HYSTERESIS:  cfg_nxt.hysteresis_mv     = cfg_wdata;
        CFG_ALARM_SPEED: cfg_nxt.alarm_motor_speed = cfg_wdata[SPD_W-1:0];
        CFG_STOP_SPEED:  cfg_nxt.stop_motor_speed  = cfg_wdata[SPD_W-1:0];
        CFG_INTERVAL:    cfg_nxt.warning_interval  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hysteresis_mv     <= RST_HYSTERESIS;
      cfg_r.alarm_motor_speed <= RST_ALARM_SPEED;
      cfg_r.stop_motor_speed  <= RST_STOP_SPEED;
      cfg_r.warning_interval  <= RST_INTERVAL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/hac_core.sv
// Mode, stored levels and tick state of the hysteresis alarm controller;
// computes one result per word. Depends on hac_pkg.
module hac_core
  import hac_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [2:0]       operation,
  input  logic [VAL_W-1:0] value,
  input  cfg_t             cfg,
  output result_t          res
);

  mode_t                   mode_r, mode_nxt;
  logic [VAL_W-1:0]        sensor_r, sensor_nxt;
  logic [VAL_W-1:0]        thresh_r, thresh_nxt;
  logic                    phase_r, phase_nxt;
  logic [VAL_W-1:0]        count_r, count_nxt;
  logic                    ind_r, ind_nxt;
  logic signed [SPD_W-1:0] motor_r, motor_nxt;
  logic [VAL_W-1:0]        count_inc;
  logic                    pulse;
  logic                    alarm_now;

  function automatic mode_t auto_eval(mode_t m, logic [VAL_W-1:0] s,
                                      logic [VAL_W-1:0] t, logic [VAL_W-1:0] h);
    mode_t r;
    r = m;
    if (m == MODE_AUTO_MONITOR) begin
      if (s > t) r = MODE_AUTO_ALARM;
    end else if (m == MODE_AUTO_ALARM) begin
      if (({1'b0, s} + {1'b0, h}) < {1'b0, t}) r = MODE_AUTO_MONITOR;
    end
    return r;
  endfunction

  assign alarm_now = (mode_r == MODE_AUTO_ALARM) || (mode_r == MODE_MANUAL_ON);
  assign count_inc = count_r + VAL_W'(1);

  always_comb begin
    mode_nxt   = mode_r;
    sensor_nxt = sensor_r;
    thresh_nxt = thresh_r;
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    ind_nxt    = ind_r;
    motor_nxt  = motor_r;
    pulse      = 1'b0;
    unique case (operation)
      OP_SENSOR: begin
        sensor_nxt = value;
        mode_nxt   = auto_eval(mode_r, value, thresh_r, cfg.hysteresis_mv);
      end
      OP_SET_AUTO: begin
        mode_nxt = (sensor_r > thresh_r) ? MODE_AUTO_ALARM : MODE_AUTO_MONITOR;
      end
      OP_MANUAL_ON:  mode_nxt = MODE_MANUAL_ON;
      OP_MANUAL_OFF: mode_nxt = MODE_MANUAL_OFF;
      OP_THRESHOLD: begin
        thresh_nxt = value;
        mode_nxt   = auto_eval(mode_r, sensor_r, value, cfg.hysteresis_mv);
      end
      OP_TICK: begin
        if (alarm_now) begin
          phase_nxt = ~phase_r;
          ind_nxt   = ~phase_r;
          motor_nxt = cfg.alarm_motor_speed;
          if (count_inc >= cfg.warning_interval) begin
            count_nxt = '0;
            pulse     = 1'b1;
          end else begin
            count_nxt = count_inc;
          end
        end else begin
          phase_nxt = 1'b0;
          count_nxt = '0;
          ind_nxt   = 1'b0;
          motor_nxt = cfg.stop_motor_speed;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_AUTO_MONITOR;
      sensor_r <= '0;
      thresh_r <= DEFAULT_THRESHOLD_MV;
      phase_r  <= 1'b0;
      count_r  <= '0;
      ind_r    <= 1'b0;
      motor_r  <= '0;
    end else if (step) begin
      mode_r   <= mode_nxt;
      sensor_r <= sensor_nxt;
      thresh_r <= thresh_nxt;
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      ind_r    <= ind_nxt;
      motor_r  <= motor_nxt;
    end
  end

  always_comb begin
    res.mode          = mode_nxt;
    res.alarm_active  = (mode_nxt == MODE_AUTO_ALARM) || (mode_nxt == MODE_MANUAL_ON);
    res.manual_mode   = (mode_nxt == MODE_MANUAL_ON) || (mode_nxt == MODE_MANUAL_OFF);
    res.indicator_on  = ind_nxt;
    res.motor_drive   = motor_nxt;
    res.warning_pulse = pulse;
  end

endmodule

// File: rtl/hysteresis_alarm_controller_top.sv
// Hysteresis alarm controller, top level. Every input word gives one result word: an
// accepted word waits in the input register, which feeds the decision logic, and that
// loads the result register once it is empty or being taken. One word per cycle is
// sustained while the receiver takes results; the result and input registers together
// let a new word enter while a result waits to be taken. Configuration writes take effect
// at the next edge. Depends on hac_pkg, hac_cfg_regs, hac_core and the macros header.
`include "hysteresis_alarm_controller_top_macros.svh"
module hysteresis_alarm_controller_top
  import hac_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              in_operation,
  input  logic [VAL_W-1:0]        in_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_mode,
  output logic                    out_alarm_active,
  output logic                    out_manual_mode,
  output logic                    out_indicator_on,
  output logic signed [SPD_W-1:0] out_motor_drive,
  output logic                    out_warning_pulse,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  logic             in_vld_r;
  logic [2:0]       op_r;
  logic [VAL_W-1:0] val_r;
  logic             out_vld_r;
  result_t          res_r;
  result_t          res_nxt;
  cfg_t             cfg;
  logic             advance;

  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  hac_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hac_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .operation (op_r),
    .value     (val_r),
    .cfg       (cfg),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) in_vld_r <= in_valid;
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r  <= in_operation;
      val_r <= in_value;
    end
    if (advance) res_r <= res_nxt;
  end

  assign out_valid         = out_vld_r;
  assign out_mode          = res_r.mode;
  assign out_alarm_active  = res_r.alarm_active;
  assign out_manual_mode   = res_r.manual_mode;
  assign out_indicator_on  = res_r.indicator_on;
  assign out_motor_drive   = res_r.motor_drive;
  assign out_warning_pulse = res_r.warning_pulse;

  `HAC_ASSERT_SAME(a_pulse_in_alarm, out_vld_r && res_r.warning_pulse, res_r.alarm_active)
  `HAC_ASSERT_NEXT(a_advance_fills_out, advance, out_vld_r)
  `HAC_ASSERT_SAME(a_stall_only_on_full, in_vld_r && !in_ready, out_vld_r && !out_ready)

endmodule

// File: dv/tb_top.sv
// Self-checking bench for hysteresis_alarm_controller_top: a queue-fed driver, a monitor and
// a bit-true status predictor, run over directed and random command words and register settings.
// Depends on hac_pkg and the RTL of hysteresis_alarm_controller_top.
module tb_top;
  import hac_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int LIMIT_CYCLES = 200000;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int ITEMS_PER_PHASE = 137;

  typedef struct packed {
    logic [2:0]       op;
    logic [VAL_W-1:0] value;
  } cmd_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_operation = '0;
  logic [VAL_W-1:0] in_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_mode;
  logic out_alarm_active;
  logic out_manual_mode;
  logic out_indicator_on;
  logic signed [SPD_W-1:0] out_motor_drive;
  logic out_warning_pulse;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  hysteresis_alarm_controller_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_mode(out_mode), .out_alarm_active(out_alarm_active),
    .out_manual_mode(out_manual_mode), .out_indicator_on(out_indicator_on),
    .out_motor_drive(out_motor_drive), .out_warning_pulse(out_warning_pulse),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Predictor state and its copy of the registers.
  logic [VAL_W-1:0]        hyst_mv = RST_HYSTERESIS;
  logic signed [SPD_W-1:0] alarm_spd = RST_ALARM_SPEED;
  logic signed [SPD_W-1:0] stop_spd = RST_STOP_SPEED;
  logic [VAL_W-1:0]        interval = RST_INTERVAL;
  mode_t                   mode_q = MODE_AUTO_MONITOR;
  logic [VAL_W-1:0]        sense_lvl = '0;
  logic [VAL_W-1:0]        thresh_mv = DEFAULT_THRESHOLD_MV;
  logic                    blink_q = 1'b0;
  logic [VAL_W-1:0]        tick_cnt = '0;
  logic                    ind_q = 1'b0;
  logic signed [SPD_W-1:0] motor_q = '0;

  cmd_word_t pending_cmds[$];
  result_t   expected_status[$];
  result_t   exp_r;
  cmd_word_t cur_cmd;

  int n_queued = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_pulses = 0;
  int n_err = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  logic in_taken = 1'b0;
  logic [VAL_W-1:0] gen_thr = DEFAULT_THRESHOLD_MV;

  function automatic logic alarm_on();
    return (mode_q == MODE_AUTO_ALARM) || (mode_q == MODE_MANUAL_ON);
  endfunction

  function automatic void auto_decide();
    if (mode_q == MODE_AUTO_MONITOR) begin
      if (sense_lvl > thresh_mv) mode_q = MODE_AUTO_ALARM;
    end else if (mode_q == MODE_AUTO_ALARM) begin
      if (({1'b0, sense_lvl} + {1'b0, hyst_mv}) < {1'b0, thresh_mv}) mode_q = MODE_AUTO_MONITOR;
    end
  endfunction

  function automatic result_t step_alarm(logic [2:0] op, logic [VAL_W-1:0] val);
    result_t r;
    logic pulse;
    pulse = 1'b0;
    case (op)
      OP_SENSOR: begin
        sense_lvl = val;
        auto_decide();
      end
      OP_SET_AUTO: mode_q = (sense_lvl > thresh_mv) ? MODE_AUTO_ALARM : MODE_AUTO_MONITOR;
      OP_MANUAL_ON: mode_q = MODE_MANUAL_ON;
      OP_MANUAL_OFF: mode_q = MODE_MANUAL_OFF;
      OP_THRESHOLD: begin
        thresh_mv = val;
        auto_decide();
      end
      OP_TICK: begin
        if (alarm_on()) begin
          blink_q = ~blink_q;
          ind_q = blink_q;
          motor_q = alarm_spd;
          tick_cnt = tick_cnt + 1'b1;
          if (tick_cnt >= interval) begin
            tick_cnt = '0;
            pulse = 1'b1;
          end
        end else begin
          blink_q = 1'b0;
          tick_cnt = '0;
          ind_q = 1'b0;
          motor_q = stop_spd;
        end
      end
      default: ;
    endcase
    r.mode = mode_q;
    r.alarm_active = alarm_on();
    r.manual_mode = (mode_q == MODE_MANUAL_ON) || (mode_q == MODE_MANUAL_OFF);
    r.indicator_on = ind_q;
    r.motor_drive = motor_q;
    r.warning_pulse = pulse;
    return r;
  endfunction

  function automatic void check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      n_err++;
    end
  endfunction

  // Input acceptance and prediction.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      expected_status.push_back(step_alarm(in_operation, in_value));
      n_accepted++;
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
  end

  // Driver: new word at the falling edge once the previous one is gone.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_cmd = pending_cmds.pop_front();
        in_operation <= cur_cmd.op;
        in_value <= cur_cmd.value;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver backpressure, with an occasional long hold.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_status.size() == 0) begin
        $error("result word with no expectation pending");
        n_err++;
      end else begin
        exp_r = expected_status.pop_front();
        check_field("mode", exp_r.mode, out_mode);
        check_field("alarm_active", exp_r.alarm_active, out_alarm_active);
        check_field("manual_mode", exp_r.manual_mode, out_manual_mode);
        check_field("indicator_on", exp_r.indicator_on, out_indicator_on);
        check_field("motor_drive", int'(exp_r.motor_drive), int'(out_motor_drive));
        check_field("warning_pulse", exp_r.warning_pulse, out_warning_pulse);
        n_checked++;
        if (out_warning_pulse) n_pulses++;
      end
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  task automatic queue_cmd(logic [2:0] op, logic [VAL_W-1:0] val);
    cmd_word_t c;
    c.op = op;
    c.value = val;
    if (op == OP_THRESHOLD) gen_thr = val;
    pending_cmds.push_back(c);
    n_queued++;
  endtask

  task automatic drain();
    while (n_accepted != n_queued || expected_status.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_HYSTERESIS:  hyst_mv = data;
      CFG_ALARM_SPEED: alarm_spd = data[SPD_W-1:0];
      CFG_STOP_SPEED:  stop_spd = data[SPD_W-1:0];
      CFG_INTERVAL:    interval = data;
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [VAL_W-1:0] h, logic signed [SPD_W-1:0] a,
                                logic signed [SPD_W-1:0] s, logic [VAL_W-1:0] iv);
    cfg_write(CFG_HYSTERESIS, h);
    cfg_write(CFG_ALARM_SPEED, {{(CFG_DATA_W-SPD_W){a[SPD_W-1]}}, a});
    cfg_write(CFG_STOP_SPEED, {{(CFG_DATA_W-SPD_W){s[SPD_W-1]}}, s});
    cfg_write(CFG_INTERVAL, iv);
    // unused indexes must not disturb anything
    for (int i = int'(CFG_INTERVAL) + 1; i < (1 << CFG_IDX_W); i++)
      cfg_write(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
  endtask

  task automatic apply_random_settings();
    apply_settings(VAL_W'($urandom_range(0, 3000)), SPD_W'($urandom_range(0, 255)),
                   SPD_W'($urandom_range(0, 255)), VAL_W'($urandom_range(1, 12)));
  endtask

  task automatic queue_random_cmd();
    int sel;
    int h;
    int v;
    sel = $urandom_range(99);
    h = int'(hyst_mv);
    if (h > 4000) h = 4000;
    if (sel < 30) begin
      v = int'(gen_thr) + int'($urandom_range(0, h + 80)) - (h + 40);
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      queue_cmd(OP_SENSOR, VAL_W'(v));
    end else if (sel < 62) begin
      queue_cmd(OP_TICK, VAL_W'($urandom));
    end else if (sel < 70) begin
      if ($urandom_range(1)) queue_cmd(OP_THRESHOLD, VAL_W'($urandom));
      else queue_cmd(OP_THRESHOLD, VAL_W'($urandom_range(500, 4000)));
    end else if (sel < 79) begin
      queue_cmd(OP_SET_AUTO, VAL_W'($urandom));
    end else if (sel < 84) begin
      queue_cmd(OP_MANUAL_ON, VAL_W'($urandom));
    end else if (sel < 89) begin
      queue_cmd(OP_MANUAL_OFF, VAL_W'($urandom));
    end else if (sel < 94) begin
      queue_cmd($urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7, VAL_W'($urandom));
    end else begin
      queue_cmd(OP_SENSOR, VAL_W'($urandom));
    end
  endtask

  task automatic run_phase(int snd, int rcv, bit long_hold, bit mid_pause);
    send_idle_pct = snd;
    recv_stall_pct = rcv;
    if (long_hold) hold_req++;
    for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
      if (mid_pause && i == ITEMS_PER_PHASE / 2) drain();
      queue_random_cmd();
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, hysteresis edges, manual modes, spare codes
    queue_cmd(OP_TICK, 16'h0000);
    queue_cmd(OP_SENSOR, 16'hFFFF);
    queue_cmd(OP_TICK, 16'hFFFF);
    queue_cmd(OP_TICK, 16'h0000);
    queue_cmd(OP_SENSOR, 16'd1950);
    queue_cmd(OP_SENSOR, 16'd1899);
    queue_cmd(OP_THRESHOLD, 16'h0000);
    queue_cmd(OP_THRESHOLD, 16'hFFFF);
    queue_cmd(OP_SENSOR, 16'hFFFF);
    queue_cmd(OP_THRESHOLD, 16'h0000);
    queue_cmd(OP_SENSOR, 16'h0000);
    queue_cmd(OP_SPARE_6, 16'hFFFF);
    queue_cmd(OP_SPARE_7, 16'h5555);
    queue_cmd(OP_MANUAL_OFF, 16'h0000);
    queue_cmd(OP_TICK, 16'h0000);
    queue_cmd(OP_SENSOR, 16'hFFFF);
    queue_cmd(OP_SET_AUTO, 16'h0000);
    queue_cmd(OP_MANUAL_ON, 16'hFFFF);
    queue_cmd(OP_THRESHOLD, 16'hFFFF);
    queue_cmd(OP_TICK, 16'h0000);
    queue_cmd(OP_SET_AUTO, 16'hFFFF);
    queue_cmd(OP_TICK, 16'h0000);
    queue_cmd(OP_SENSOR, 16'hAAAA);
    drain();

    apply_settings(16'd0, 8'sd127, -8'sd128, 16'd1);
    run_phase(0, 0, 1'b0, 1'b0);
    apply_settings(16'hFFFF, -8'sd128, 8'sd127, 16'd0);
    run_phase(76, 0, 1'b0, 1'b0);
    apply_settings(16'd500, SPD_W'($urandom), SPD_W'($urandom), 16'd3);
    run_phase(0, 76, 1'b0, 1'b0);
    apply_random_settings();
    run_phase(18, 18, 1'b0, 1'b1);
    apply_settings(RST_HYSTERESIS, RST_ALARM_SPEED, RST_STOP_SPEED, 16'hFFFF);
    run_phase(0, 0, 1'b1, 1'b0);
    apply_random_settings();
    run_phase(76, 0, 1'b0, 1'b0);
    apply_random_settings();
    run_phase(0, 76, 1'b0, 1'b0);
    apply_settings(16'd0, 8'sd127, -8'sd128, 16'd2);
    run_phase(18, 18, 1'b0, 1'b0);

    repeat (10) @(negedge clk);
    if (expected_status.size() != 0) begin
      $error("%0d expected result words never arrived", expected_status.size());
      n_err++;
    end
    $display("Checked %0d of %0d words over nine register settings, all six operations",
             n_checked, n_accepted);
    $display("plus spare codes, idle and stall mixes, long backpressure; %0d warning pulses seen",
             n_pulses);
    if (n_err == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
